// ===== rtl/ucd_pkg.sv =====
// Shared types, constants and the byte classifier for the UTF-8 decoder.
// No dependencies; every other file in rtl/ refers to it by scoped name.
package ucd_pkg;

    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QPTR_W  = $clog2(QDEPTH);
    localparam logic [31:0] BAD_POINT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [31:0] code_point;
        logic        run_last;
    } out_item_t;

    // One command per byte that has results: last_idx + 1 results, all of
    // them BAD_POINT except the final one, which carries the tail.
    typedef struct packed {
        logic [1:0]  last_idx;
        logic        tail_bad;
        logic [20:0] tail_cp;
    } cmd_t;

    // Queue status seen by the back end.
    typedef struct packed {
        logic empty;
        cmd_t head;
    } q_status_t;

    typedef enum logic [2:0] {
        KIND_CONT,
        KIND_ASCII,
        KIND_LEAD2,
        KIND_LEAD3,
        KIND_LEAD4,
        KIND_INVALID
    } byte_kind_t;

    function automatic byte_kind_t byte_kind(input logic [7:0] b);
        byte_kind_t k;
        unique case (b[7:3]) inside
            [5'd0:5'd15]:   k = KIND_ASCII;
            [5'd16:5'd23]:  k = KIND_CONT;
            [5'd24:5'd27]:  k = KIND_LEAD2;
            [5'd28:5'd29]:  k = KIND_LEAD3;
            5'd30:          k = KIND_LEAD4;
            default:        k = KIND_INVALID;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/ucd_front.sv =====
// Front end: classifies each byte, tracks the open sequence, and issues one
// result command per byte that has results. Depends on ucd_pkg.
module ucd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ucd_pkg::in_item_t s_item,
    input  logic              q_full,
    output logic              cmd_push,
    output ucd_pkg::cmd_t     cmd
);

    logic [7:0]  lead_reg,  lead_next;
    logic [1:0]  need_reg,  need_next;
    logic [1:0]  cnt_reg,   cnt_next;
    logic [17:0] bits_reg,  bits_next;

    ucd_pkg::byte_kind_t kind;
    logic        accept;
    logic        emit;
    logic [1:0]  cnt_inc;
    logic [17:0] bits_inc;
    logic        fresh_result;
    logic        fresh_ascii;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign kind    = ucd_pkg::byte_kind(s_item.in_byte);
    assign cnt_inc  = cnt_reg + 2'd1;
    assign bits_inc = {bits_reg[11:0], s_item.in_byte[5:0]};

    // Byte decoded afresh gives a result unless it opens a sequence.
    assign fresh_ascii  = (kind == ucd_pkg::KIND_ASCII);
    assign fresh_result = fresh_ascii || (kind == ucd_pkg::KIND_CONT)
                       || (kind == ucd_pkg::KIND_INVALID) || s_item.end_of_string;

    always_comb begin
        lead_next     = lead_reg;
        need_next     = need_reg;
        cnt_next      = cnt_reg;
        bits_next     = bits_reg;
        emit          = 1'b0;
        cmd.last_idx  = 2'd0;
        cmd.tail_bad  = 1'b1;
        cmd.tail_cp   = '0;
        if (need_reg != 2'd0 && kind == ucd_pkg::KIND_CONT) begin
            if (cnt_inc == need_reg) begin
                emit         = 1'b1;
                cmd.tail_bad = 1'b0;
                case (need_reg)
                    2'd1:    cmd.tail_cp = {10'd0, lead_reg[4:0], bits_inc[5:0]};
                    2'd2:    cmd.tail_cp = {5'd0, lead_reg[3:0], bits_inc[11:0]};
                    default: cmd.tail_cp = {lead_reg[2:0], bits_inc};
                endcase
                lead_next = '0;
                need_next = '0;
                cnt_next  = '0;
                bits_next = '0;
            end else if (s_item.end_of_string) begin
                // truncated: lead, held continuations and this byte
                emit         = 1'b1;
                cmd.last_idx = cnt_inc;
                lead_next    = '0;
                need_next    = '0;
                cnt_next     = '0;
                bits_next    = '0;
            end else begin
                cnt_next  = cnt_inc;
                bits_next = bits_inc;
            end
        end else begin
            // broken sequence flushes first, then the byte is decoded afresh
            if (need_reg != 2'd0) begin
                emit         = 1'b1;
                cmd.last_idx = cnt_reg;
            end
            if (fresh_result) begin
                if (need_reg != 2'd0) begin
                    cmd.last_idx = cnt_inc;
                end
                emit         = 1'b1;
                cmd.tail_bad = !fresh_ascii;
                cmd.tail_cp  = {14'd0, s_item.in_byte[6:0]};
                lead_next    = '0;
                need_next    = '0;
            end else begin
                lead_next = s_item.in_byte;
                unique case (kind)
                    ucd_pkg::KIND_LEAD2: need_next = 2'd1;
                    ucd_pkg::KIND_LEAD3: need_next = 2'd2;
                    default:             need_next = 2'd3;
                endcase
            end
            cnt_next  = '0;
            bits_next = '0;
        end
    end

    assign cmd_push = accept && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_reg <= '0;
            need_reg <= '0;
            cnt_reg  <= '0;
            bits_reg <= '0;
        end else if (accept) begin
            lead_reg <= lead_next;
            need_reg <= need_next;
            cnt_reg  <= cnt_next;
            bits_reg <= bits_next;
        end
    end

endmodule

// ===== rtl/ucd_queue.sv =====
// Small command queue between the front and back ends.
// Depends on ucd_pkg for the command type and depth.
module ucd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ucd_pkg::cmd_t       push_cmd,
    output logic                full,
    input  logic                pop,
    output ucd_pkg::q_status_t  status
);

    ucd_pkg::cmd_t entry_reg [ucd_pkg::QDEPTH];
    logic [ucd_pkg::QPTR_W:0] wr_reg, wr_next;
    logic [ucd_pkg::QPTR_W:0] rd_reg, rd_next;

    assign full = (wr_reg[ucd_pkg::QPTR_W] != rd_reg[ucd_pkg::QPTR_W])
               && (wr_reg[ucd_pkg::QPTR_W-1:0] == rd_reg[ucd_pkg::QPTR_W-1:0]);
    assign status.empty = (wr_reg == rd_reg);
    assign status.head  = entry_reg[rd_reg[ucd_pkg::QPTR_W-1:0]];

    assign wr_next = wr_reg + (ucd_pkg::QPTR_W+1)'(1);
    assign rd_next = rd_reg + (ucd_pkg::QPTR_W+1)'(1);

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_reg[ucd_pkg::QPTR_W-1:0]] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_next;
            end
            if (pop) begin
                rd_reg <= rd_next;
            end
        end
    end

endmodule

// ===== rtl/ucd_back.sv =====
// Back end: expands each queued command into its result items, one per cycle
// while m_ready allows, into a registered output stage. Depends on ucd_pkg.
module ucd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  ucd_pkg::q_status_t  status,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output ucd_pkg::out_item_t  m_item
);

    logic                m_valid_reg, m_valid_next;
    ucd_pkg::out_item_t  item_reg, item_next;
    logic [1:0]          idx_reg, idx_next;
    logic                load;
    logic                last;

    assign load = !status.empty && (!m_valid_reg || m_ready);
    assign last = (idx_reg == status.head.last_idx);
    assign pop  = load && last;

    always_comb begin
        item_next    = item_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (load) begin
            m_valid_next       = 1'b1;
            item_next.run_last = last;
            if (last && !status.head.tail_bad) begin
                item_next.code_point = {11'd0, status.head.tail_cp};
            end else begin
                item_next.code_point = ucd_pkg::BAD_POINT;
            end
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = item_reg;

endmodule

// ===== rtl/utf8_codepoint_decoder_core.sv =====
// Top level of the streaming UTF-8 to code point decoder.
// Depends on ucd_pkg, ucd_front, ucd_queue and ucd_back.
//
// The decoder takes one UTF-8 byte per item, with a flag for the last byte of
// a string, and gives one 32-bit code point per complete sequence. A stray
// continuation, an invalid byte (F8-FF), a lead marked last, a truncated or a
// broken sequence gives FFFFFFFF for each byte involved; a byte that breaks a
// sequence is then decoded on its own. No overlong or surrogate check is made.
// run_last marks the final result caused by each input item; a lead byte that
// opens a sequence gives no result. Throughput: one input item per cycle as
// long as the four-entry command queue has room. Each item's results leave
// the output register one per cycle while m_ready allows; a byte gives 1 to 4
// results and the queue absorbs those bursts. With an idle queue and output
// register, an accepted byte's command is written to the queue, then the back
// end loads its first result into the output register that drives m_valid.
module utf8_codepoint_decoder_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ucd_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output ucd_pkg::out_item_t m_item
);

    logic               q_full;
    logic               cmd_push;
    ucd_pkg::cmd_t      cmd;
    logic               cmd_pop;
    ucd_pkg::q_status_t q_status;

    // classify and track the open sequence
    ucd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .q_full   (q_full),
        .cmd_push (cmd_push),
        .cmd      (cmd)
    );

    // decouples byte intake from result delivery
    ucd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (cmd_push),
        .push_cmd (cmd),
        .full     (q_full),
        .pop      (cmd_pop),
        .status   (q_status)
    );

    // one result item per cycle into the output register while m_ready allows
    ucd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .status   (q_status),
        .pop      (cmd_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

// ===== sim/utf8_codepoint_decoder_core_tb.sv =====
// Testbench for utf8_codepoint_decoder_core: byte stream in, code points out.
// Depends on ucd_pkg (item types, byte kinds, BAD_POINT) and the decoder RTL.
// A predictor tracks the open sequence and queues the code points each byte yields.
module utf8_codepoint_decoder_core_tb;

    localparam int ITEM_TARGET  = 360;
    localparam int HOLD_CYCLES  = 60;        // long receiver hold-off
    localparam int DRAIN_CYCLES = 8;         // settle time after the last result
    localparam int TIMEOUT      = 6_000_000; // far beyond the slowest legal run
    localparam int MAX_REPORTS  = 10;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    ucd_pkg::in_item_t  s_item  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    ucd_pkg::out_item_t m_item;

    // Code points still owed by the block, oldest first.
    ucd_pkg::out_item_t expected_points[$];
    int                 mismatches = 0;
    int                 sent_items = 0;

    // calm_mode: neither side idles. hold_req: receiver does one long hold-off.
    bit calm_mode = 1'b0;
    bit hold_req  = 1'b0;

    // Predictor copy of the decoder's open sequence.
    logic [7:0]  seq_lead = '0;
    logic [1:0]  seq_need = '0;   // continuations still required in total; 0 = none open
    logic [1:0]  seq_got  = '0;
    logic [17:0] seq_bits = '0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    utf8_codepoint_decoder_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    function automatic ucd_pkg::byte_kind_t classify(input logic [7:0] b);
        if (!b[7])                return ucd_pkg::KIND_ASCII;
        if (b[7:6] == 2'b10)      return ucd_pkg::KIND_CONT;
        if (b[7:5] == 3'b110)     return ucd_pkg::KIND_LEAD2;
        if (b[7:4] == 4'b1110)    return ucd_pkg::KIND_LEAD3;
        if (b[7:3] == 5'b11110)   return ucd_pkg::KIND_LEAD4;
        return ucd_pkg::KIND_INVALID;
    endfunction

    // Idle length: one of three random ranges, the shortest most likely, the longest rarest.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 92) return $urandom_range(3, 6);
        return $urandom_range(12, 40);
    endfunction

    // Work out the code points one accepted byte yields and queue them.
    task automatic predict_byte(input logic [7:0] b, input logic eos);
        logic [31:0]         pts[$];
        logic [31:0]         cp;
        ucd_pkg::byte_kind_t k;
        ucd_pkg::out_item_t  r;
        k = classify(b);
        if (seq_need != 2'd0 && k == ucd_pkg::KIND_CONT) begin
            seq_bits = {seq_bits[11:0], b[5:0]};
            seq_got  = seq_got + 2'd1;
            if (seq_got == seq_need) begin
                unique case (seq_need)
                    2'd1:    cp = {21'd0, seq_lead[4:0], seq_bits[5:0]};
                    2'd2:    cp = {16'd0, seq_lead[3:0], seq_bits[11:0]};
                    default: cp = {11'd0, seq_lead[2:0], seq_bits};
                endcase
                pts.push_back(cp);
                {seq_lead, seq_need, seq_got, seq_bits} = '0;
            end else if (eos) begin
                // truncated: lead, held continuations and this one are all bad
                repeat (int'(seq_got) + 1) pts.push_back(ucd_pkg::BAD_POINT);
                {seq_lead, seq_need, seq_got, seq_bits} = '0;
            end
        end else begin
            if (seq_need != 2'd0) begin
                // broken sequence: flush it, then decode this byte on its own
                repeat (int'(seq_got) + 1) pts.push_back(ucd_pkg::BAD_POINT);
                {seq_lead, seq_need, seq_got, seq_bits} = '0;
            end
            case (k) inside
                ucd_pkg::KIND_ASCII: pts.push_back({24'd0, b});
                ucd_pkg::KIND_LEAD2, ucd_pkg::KIND_LEAD3, ucd_pkg::KIND_LEAD4: begin
                    if (eos) begin
                        pts.push_back(ucd_pkg::BAD_POINT);
                    end else begin
                        seq_lead = b;
                        seq_need = (k == ucd_pkg::KIND_LEAD2) ? 2'd1 :
                                   (k == ucd_pkg::KIND_LEAD3) ? 2'd2 : 2'd3;
                        seq_got  = 2'd0;
                        seq_bits = '0;
                    end
                end
                default: pts.push_back(ucd_pkg::BAD_POINT);
            endcase
        end
        foreach (pts[i]) begin
            r.code_point = pts[i];
            r.run_last   = (i == pts.size() - 1);
            expected_points.push_back(r);
        end
    endtask

    // Monitor: values read right after the edge are the ones the block sampled.
    always @(posedge aclk) begin
        ucd_pkg::out_item_t want;
        if (aresetn && s_valid && s_ready)
            predict_byte(s_item.in_byte, s_item.end_of_string);
        if (aresetn && m_valid && m_ready) begin
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: cp=%h last=%b",
                             m_item.code_point, m_item.run_last);
            end else begin
                want = expected_points.pop_front();
                if (want.code_point !== m_item.code_point ||
                    want.run_last !== m_item.run_last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected cp=%h last=%b, got cp=%h last=%b",
                                 want.code_point, want.run_last,
                                 m_item.code_point, m_item.run_last);
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (!calm_mode && $urandom_range(0, 3) == 0) begin
                stall_left = idle_len() - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one item and hold it until accepted. Valid is lowered only when a
    // gap follows, so back-to-back items never see valid drop and rise in one step.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        gap = (calm_mode || $urandom_range(0, 2) != 0) ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= '{in_byte: b, end_of_string: eos};
        do @(posedge aclk); while (!s_ready);
        sent_items++;
    endtask

    // Sender pause: idle until every owed result is back.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_points.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One character of len bytes with random payload; a partial one stops early.
    task automatic send_char(input int len, input bit whole, input bit last);
        logic [7:0] seq[4];
        int         cnt;
        case (len)
            1:       seq[0] = 8'($urandom_range(0, 127));
            2:       seq[0] = 8'hC0 | 8'($urandom_range(0, 31));
            3:       seq[0] = 8'hE0 | 8'($urandom_range(0, 15));
            default: seq[0] = 8'hF0 | 8'($urandom_range(0, 7));
        endcase
        for (int i = 1; i < 4; i++)
            seq[i] = 8'h80 | 8'($urandom_range(0, 63));
        cnt = (whole || len == 1) ? len : $urandom_range(1, len - 1);
        for (int i = 0; i < cnt; i++)
            send_byte(seq[i], last && i == cnt - 1);
    endtask

    task automatic test_directed();
        send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b1);                   // ASCII bounds
        send_byte(8'hC2, 1'b0); send_byte(8'hA9, 1'b1);                   // 2-byte ends string
        send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hAC, 1'b0);
        send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0);                   // 4-byte
        send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b1);
        send_byte(8'h80, 1'b0);                                           // stray continuation
        send_byte(8'hF8, 1'b0); send_byte(8'hFF, 1'b0);                   // invalid bytes
        send_byte(8'hC3, 1'b1);                                           // lead marked last
        send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);                   // truncated
        send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0);                   // broken by ASCII,
        send_byte(8'h98, 1'b0); send_byte(8'h41, 1'b0);                   // four results
        send_byte(8'hE0, 1'b0); send_byte(8'hC2, 1'b0);                   // broken by a lead,
        send_byte(8'hA9, 1'b1);                                           // which then completes
        drain_results();
    endtask

    // Receiver holds off while the sender keeps offering single-result bytes,
    // so the command queue fills and s_ready must drop.
    task automatic test_output_stall();
        calm_mode = 1'b1;
        hold_req  = 1'b1;
        for (int i = 0; i < 32; i++)
            send_byte(i[0] ? (8'hF8 | 8'(i)) : 8'(i + 32), i == 31);
        calm_mode = 1'b0;
        drain_results();
    endtask

    // Strings of mostly well-formed characters, some cut short, some noise.
    task automatic test_random_strings();
        int nchars;
        int r;
        while (sent_items < ITEM_TARGET) begin
            calm_mode = ($urandom_range(0, 5) == 0);
            nchars    = $urandom_range(1, 10);
            for (int c = 0; c < nchars; c++) begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    send_char($urandom_range(1, 4), 1'b1, c == nchars - 1);
                else if (r < 88)
                    send_char($urandom_range(2, 4), 1'b0, c == nchars - 1);
                else
                    send_byte(8'($urandom), $urandom_range(0, 7) == 0);
            end
            if ($urandom_range(0, 19) == 0)
                drain_results();
        end
        calm_mode = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_output_stall();
        test_random_strings();
        drain_results();
        if (expected_points.size() != 0)
            $display("results missing: %0d", expected_points.size());
        if (mismatches == 0 && expected_points.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #(TIMEOUT);
        $display("timeout");
        $display("status: fail");
        $finish;
    end

endmodule
